>>> design/counting_bloom_filter_unit_assert.svh
// ---------------------------------------------------------------------------
// Assertion macros for the counting Bloom filter unit
// Shared property templates; each use expands to one labeled assertion.
// ---------------------------------------------------------------------------
`ifndef COUNTING_BLOOM_FILTER_UNIT_ASSERT_SVH
`define COUNTING_BLOOM_FILTER_UNIT_ASSERT_SVH

// Antecedent implies consequent in the same cycle.
`define CBF_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Antecedent forbids the given condition in the same cycle.
`define CBF_ASSERT_NEVER(label, clk, rst_n, ante, bad, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> !(bad)) \
        else $error(msg);

`endif

>>> design/cbf_pkg.sv
// ---------------------------------------------------------------------------
// cbf_pkg
// Shared types and constants of the counting Bloom filter unit.
// ---------------------------------------------------------------------------
package cbf_pkg;

    localparam int CMD_W = 2;
    localparam int KEY_W = 32;
    localparam int CTR_W = 4;

    // command codes
    localparam logic [CMD_W-1:0] CMD_ADD    = 2'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK  = 2'd2;

    // counter limits
    localparam logic [CTR_W-1:0] CTR_MAX  = 4'hF;
    localparam logic [CTR_W-1:0] CTR_ZERO = 4'h0;

    // murmur3 finalizer multipliers
    localparam logic [31:0] FMIX_C1 = 32'h85ebca6b;
    localparam logic [31:0] FMIX_C2 = 32'hc2b2ae35;

    // slot queue between front and back
    localparam int QUEUE_DEPTH = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;

    // hash pipeline depth and its in-flight counter
    localparam int PIPE_DEPTH = 6;
    localparam int INFL_W     = 3;

    // operation attached to one slot access
    typedef struct packed {
        logic is_check;
        logic is_add;
        logic last;
    } t_op;

endpackage

>>> design/cbf_ram.sv
// ---------------------------------------------------------------------------
// cbf_ram
// Generic single-write, single-read RAM with registered read data.
// ---------------------------------------------------------------------------
module cbf_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // read returns the old word on a same-address write
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/cbf_front.sv
// ---------------------------------------------------------------------------
// cbf_front
// Command intake and slot hashing: one hash index per cycle, when the queue
// has room, through a six-stage murmur3 finalizer and modulo pipeline into it.
// ---------------------------------------------------------------------------
module cbf_front #(
    parameter int NUM_SLOTS  = 1048576,
    parameter int HASH_COUNT = 10
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    output logic                           o_busy,
    input  logic [cbf_pkg::CMD_W-1:0]      i_cmd,
    input  logic [cbf_pkg::KEY_W-1:0]      i_key,
    input  logic                           i_clearing,
    input  logic [cbf_pkg::QCNT_W-1:0]     i_q_count,
    output logic                           o_push,
    output cbf_pkg::t_op                   o_op,
    output logic [$clog2(NUM_SLOTS)-1:0]   o_slot
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam int REM_W  = SLOT_W + 1;
    localparam int IDX_W  = (HASH_COUNT > 1) ? $clog2(HASH_COUNT) : 1;
    localparam int SUM_W  = cbf_pkg::QCNT_W + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(HASH_COUNT - 1);
    localparam logic [31:0]      RECIP    = 32'(64'h1_0000_0000 / 64'(NUM_SLOTS));
    localparam logic [31:0]      NSL      = 32'(NUM_SLOTS);
    localparam logic [REM_W-1:0] NREM     = REM_W'(NUM_SLOTS);
    localparam logic [SUM_W-1:0] QDEPTH   = SUM_W'(cbf_pkg::QUEUE_DEPTH);

    logic                         r_active;
    logic [IDX_W-1:0]             r_idx;
    logic [cbf_pkg::KEY_W-1:0]    r_key;
    logic [cbf_pkg::CMD_W-1:0]    r_cmd;
    logic [cbf_pkg::INFL_W-1:0]   r_inflight;
    logic [cbf_pkg::INFL_W-1:0]   n_inflight;

    logic [cbf_pkg::PIPE_DEPTH-1:0] r_v;
    cbf_pkg::t_op                   r_op [cbf_pkg::PIPE_DEPTH];

    logic [31:0]       r_m1;
    logic [31:0]       r_m2;
    logic [31:0]       r_h3;
    logic [31:0]       r_q3;
    logic [31:0]       r_h4;
    logic [31:0]       r_p4;
    logic [REM_W-1:0]  r_r5;
    logic [SLOT_W-1:0] r_slot6;
    logic [SLOT_W-1:0] n_slot6;

    logic              cmd_ok;
    logic              credit_ok;
    logic              issue;
    logic              last;
    logic              accept;
    logic [SUM_W-1:0]  occ;
    logic [31:0]       seed;
    logic [31:0]       x0;
    logic [31:0]       x1;
    logic [31:0]       hv3;
    logic [63:0]       prod3;
    logic [31:0]       diff5;
    cbf_pkg::t_op      op0;

    assign cmd_ok = (i_cmd == cbf_pkg::CMD_ADD) || (i_cmd == cbf_pkg::CMD_REMOVE)
                 || (i_cmd == cbf_pkg::CMD_CHECK);

    // queue entries plus hashes in flight must fit in the queue
    assign occ       = SUM_W'(i_q_count) + SUM_W'(r_inflight);
    assign credit_ok = (occ < QDEPTH);
    assign issue     = r_active & credit_ok;
    assign last      = (r_idx == LAST_IDX);
    assign o_busy    = i_clearing | (r_active & ~(issue & last));
    assign accept    = i_start & ~o_busy;

    always_comb begin
        op0.is_check = (r_cmd == cbf_pkg::CMD_CHECK);
        op0.is_add   = (r_cmd == cbf_pkg::CMD_ADD);
        op0.last     = last;
    end

    assign seed  = r_key ^ 32'(r_idx);
    assign x0    = seed ^ (seed >> 16);
    assign x1    = r_m1 ^ (r_m1 >> 13);
    assign hv3   = r_m2 ^ (r_m2 >> 16);
    assign prod3 = 64'(hv3) * 64'(RECIP);
    assign diff5 = r_h4 - r_p4;

    // remainder estimate is below twice the slot count: one correction
    always_comb begin
        if (r_r5 >= NREM) begin
            n_slot6 = SLOT_W'(r_r5 - NREM);
        end else begin
            n_slot6 = SLOT_W'(r_r5);
        end
    end

    always_comb begin
        n_inflight = r_inflight;
        if (issue && !r_v[cbf_pkg::PIPE_DEPTH-1]) begin
            n_inflight = r_inflight + 1'b1;
        end else if (!issue && r_v[cbf_pkg::PIPE_DEPTH-1]) begin
            n_inflight = r_inflight - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= 1'b0;
            r_idx      <= '0;
            r_inflight <= '0;
            r_v        <= '0;
        end else begin
            r_inflight <= n_inflight;
            r_v        <= {r_v[cbf_pkg::PIPE_DEPTH-2:0], issue};
            if (issue) begin
                r_idx <= r_idx + 1'b1;
                if (last) begin
                    r_active <= 1'b0;
                end
            end
            // drop unused commands at intake
            if (accept && cmd_ok) begin
                r_active <= 1'b1;
                r_idx    <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_key <= i_key;
            r_cmd <= i_cmd;
        end
        r_op[0] <= op0;
        for (int s = 1; s < cbf_pkg::PIPE_DEPTH; s++) begin
            r_op[s] <= r_op[s-1];
        end
        r_m1    <= x0 * cbf_pkg::FMIX_C1;
        r_m2    <= x1 * cbf_pkg::FMIX_C2;
        r_h3    <= hv3;
        r_q3    <= prod3[63:32];
        r_h4    <= r_h3;
        r_p4    <= r_q3 * NSL;
        r_r5    <= diff5[REM_W-1:0];
        r_slot6 <= n_slot6;
    end

    assign o_push = r_v[cbf_pkg::PIPE_DEPTH-1];
    assign o_op   = r_op[cbf_pkg::PIPE_DEPTH-1];
    assign o_slot = r_slot6;

endmodule

>>> design/cbf_fifo.sv
// ---------------------------------------------------------------------------
// cbf_fifo
// Short queue of slot accesses between the hash front and the counter back.
// ---------------------------------------------------------------------------
module cbf_fifo #(
    parameter int SLOT_W = 20
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  cbf_pkg::t_op               i_op,
    input  logic [SLOT_W-1:0]          i_slot,
    input  logic                       i_pop,
    output logic                       o_valid,
    output cbf_pkg::t_op               o_op,
    output logic [SLOT_W-1:0]          o_slot,
    output logic [cbf_pkg::QCNT_W-1:0] o_count
);

    cbf_pkg::t_op      r_op_mem   [cbf_pkg::QUEUE_DEPTH];
    logic [SLOT_W-1:0] r_slot_mem [cbf_pkg::QUEUE_DEPTH];

    logic [cbf_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [cbf_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [cbf_pkg::QCNT_W-1:0] r_count;
    logic                       do_pop;

    assign do_pop = i_pop & (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && do_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_op_mem[r_wr_ptr]   <= i_op;
            r_slot_mem[r_wr_ptr] <= i_slot;
        end
    end

    assign o_valid = (r_count != '0);
    assign o_op    = r_op_mem[r_rd_ptr];
    assign o_slot  = r_slot_mem[r_rd_ptr];
    assign o_count = r_count;

endmodule

>>> design/cbf_back.sv
// ---------------------------------------------------------------------------
// cbf_back
// Counter store: clearing pass after reset, then one read-modify-write or
// check per cycle with forwarding of the previous write.
// ---------------------------------------------------------------------------
module cbf_back #(
    parameter int NUM_SLOTS = 1048576
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_q_valid,
    input  cbf_pkg::t_op                 i_q_op,
    input  logic [$clog2(NUM_SLOTS)-1:0] i_q_slot,
    output logic                         o_pop,
    output logic                         o_clearing,
    output logic                         o_valid,
    output logic                         o_present
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);
    localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(NUM_SLOTS - 1);

    logic                        r_clearing;
    logic [SLOT_W-1:0]           r_clr_addr;
    logic                        r_b_valid;
    cbf_pkg::t_op                r_b_op;
    logic [SLOT_W-1:0]           r_b_slot;
    logic                        r_fw_valid;
    logic [SLOT_W-1:0]           r_fw_slot;
    logic [cbf_pkg::CTR_W-1:0]   r_fw_data;
    logic                        r_all;
    logic                        r_valid;
    logic                        r_present;

    logic [cbf_pkg::CTR_W-1:0]   rdata;
    logic [cbf_pkg::CTR_W-1:0]   cur;
    logic [cbf_pkg::CTR_W-1:0]   upd;
    logic                        b_write;
    logic                        acc;
    logic                        we;
    logic [SLOT_W-1:0]           waddr;
    logic [cbf_pkg::CTR_W-1:0]   wdata;

    assign o_pop = i_q_valid & ~r_clearing;

    // take the value written last cycle when the slot repeats
    assign cur = (r_fw_valid && (r_fw_slot == r_b_slot)) ? r_fw_data : rdata;

    always_comb begin
        if (r_b_op.is_add) begin
            upd = (cur == cbf_pkg::CTR_MAX) ? cur : cur + 1'b1;
        end else begin
            upd = (cur == cbf_pkg::CTR_ZERO) ? cur : cur - 1'b1;
        end
    end

    assign b_write = r_b_valid & ~r_b_op.is_check;
    assign acc     = r_all & (cur != cbf_pkg::CTR_ZERO);

    assign we    = r_clearing | b_write;
    assign waddr = r_clearing ? r_clr_addr : r_b_slot;
    assign wdata = r_clearing ? cbf_pkg::CTR_ZERO : upd;

    cbf_ram #(
        .WIDTH (cbf_pkg::CTR_W),
        .DEPTH (NUM_SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (i_q_slot),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_addr <= '0;
            r_b_valid  <= 1'b0;
            r_fw_valid <= 1'b0;
            r_all      <= 1'b1;
            r_valid    <= 1'b0;
        end else begin
            if (r_clearing) begin
                r_clr_addr <= r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_SLOT) begin
                    r_clearing <= 1'b0;
                end
            end
            r_b_valid  <= o_pop;
            r_fw_valid <= b_write;
            r_valid    <= 1'b0;
            if (r_b_valid && r_b_op.is_check) begin
                if (r_b_op.last) begin
                    r_valid <= 1'b1;
                    r_all   <= 1'b1;
                end else begin
                    r_all <= acc;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_op    <= i_q_op;
        r_b_slot  <= i_q_slot;
        r_fw_slot <= r_b_slot;
        r_fw_data <= upd;
        if (r_b_valid && r_b_op.is_check && r_b_op.last) begin
            r_present <= acc;
        end
    end

    assign o_clearing = r_clearing;
    assign o_valid    = r_valid;
    assign o_present  = r_present;

endmodule

>>> design/counting_bloom_filter_unit.sv
// ---------------------------------------------------------------------------
// counting_bloom_filter_unit
// Counting Bloom filter over 32-bit keys with 4-bit saturating counters.
// ---------------------------------------------------------------------------
//
//  Channel   Direction  Handshake              Payload
//  -------   ---------  ---------------------  ------------------
//  command   in         start & !busy          i_cmd, i_key
//  result    out        o_valid (one cycle)    o_present
//
//  Flow: an add, remove or check item visits HASH_COUNT counter slots, one
//  slot per cycle while the slot queue has room, through the single read
//  and write port of the counter store; an unused command code is dropped.
//  Reset: busy stays high through a clearing pass over the NUM_SLOTS slots.
//  Stalls: the result side cannot stall; busy is the only back-pressure.
//
//  Structure: the front takes the command, runs each hash index through a
//  six-stage murmur3 finalizer and modulo pipeline and queues the slots;
//  the back drains the queue one slot per cycle against the counter store.
// ---------------------------------------------------------------------------
module counting_bloom_filter_unit #(
    parameter int NUM_SLOTS  = 1048576,
    parameter int HASH_COUNT = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [cbf_pkg::CMD_W-1:0] i_cmd,
    input  logic [cbf_pkg::KEY_W-1:0] i_key,
    output logic                      o_valid,
    output logic                      o_present
);

    localparam int SLOT_W = $clog2(NUM_SLOTS);

    // front to queue
    logic                       push;
    cbf_pkg::t_op               push_op;
    logic [SLOT_W-1:0]          push_slot;

    // queue to back
    logic                       q_valid;
    cbf_pkg::t_op               q_op;
    logic [SLOT_W-1:0]          q_slot;
    logic                       q_pop;
    logic [cbf_pkg::QCNT_W-1:0] q_count;

    // back status: hold intake off while the store is being cleared
    logic                       clearing;

    cbf_front #(
        .NUM_SLOTS  (NUM_SLOTS),
        .HASH_COUNT (HASH_COUNT)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .o_busy     (busy),
        .i_cmd      (i_cmd),
        .i_key      (i_key),
        .i_clearing (clearing),
        .i_q_count  (q_count),
        .o_push     (push),
        .o_op       (push_op),
        .o_slot     (push_slot)
    );

    cbf_fifo #(
        .SLOT_W (SLOT_W)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_op    (push_op),
        .i_slot  (push_slot),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_op    (q_op),
        .o_slot  (q_slot),
        .o_count (q_count)
    );

    cbf_back #(
        .NUM_SLOTS (NUM_SLOTS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_valid  (q_valid),
        .i_q_op     (q_op),
        .i_q_slot   (q_slot),
        .o_pop      (q_pop),
        .o_clearing (clearing),
        .o_valid    (o_valid),
        .o_present  (o_present)
    );

endmodule

>>> design/cbf_checker.sv
// ---------------------------------------------------------------------------
// cbf_checker
// Port-level checks of the counting Bloom filter unit, bound to the top.
// ---------------------------------------------------------------------------
`include "counting_bloom_filter_unit_assert.svh"

module cbf_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic [cbf_pkg::CMD_W-1:0] i_cmd,
    input logic                      o_valid
);

    logic [7:0] r_pending;
    logic [7:0] n_pending;
    logic       check_in;

    // checks taken but not yet answered
    assign check_in = start & ~busy & (i_cmd == cbf_pkg::CMD_CHECK);

    always_comb begin
        n_pending = r_pending;
        if (check_in && !o_valid) begin
            n_pending = r_pending + 1'b1;
        end else if (!check_in && o_valid) begin
            n_pending = r_pending - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pending <= '0;
        end else begin
            r_pending <= n_pending;
        end
    end

    `CBF_ASSERT_IMPLY(a_busy_after_reset, i_clk, i_rst_n, !$past(i_rst_n), busy, "not busy while clearing after reset")
    `CBF_ASSERT_NEVER(a_quiet_after_reset, i_clk, i_rst_n, !$past(i_rst_n), o_valid, "result right after reset")
    `CBF_ASSERT_IMPLY(a_result_has_check, i_clk, i_rst_n, o_valid, r_pending != 8'd0, "result with no open check")

endmodule

bind counting_bloom_filter_unit cbf_checker u_cbf_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .start   (start),
    .busy    (busy),
    .i_cmd   (i_cmd),
    .o_valid (o_valid)
);

>>> dv/cbf_membership_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// cbf_membership_checker
// Watches the command and result channels of the counting Bloom filter,
// keeps its own counter store, and compares every present bit it sees.
// ---------------------------------------------------------------------------
module cbf_membership_checker #(
    parameter int NUM_SLOTS  = 1048576,
    parameter int HASH_COUNT = 10
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic                      i_busy,
    input  logic [cbf_pkg::CMD_W-1:0] i_cmd,
    input  logic [cbf_pkg::KEY_W-1:0] i_key,
    input  logic                      i_valid,
    input  logic                      i_present,
    output int                        o_fail_count,
    output int                        o_pending,
    output logic [cbf_pkg::KEY_W-1:0] o_twin_key
);

    // Shadow counter store; bit storage starts at zero, which matches the
    // cleared state after reset.
    bit [cbf_pkg::CTR_W-1:0] counters [NUM_SLOTS];
    bit                      present_expected [$];
    int                      fail_count = 0;
    int                      pending    = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending;

    function automatic int unsigned counter_slot(input logic [cbf_pkg::KEY_W-1:0] key,
                                                 input int unsigned idx);
        logic [31:0] h;
        h = key ^ idx;
        h = h ^ (h >> 16);
        h = h * cbf_pkg::FMIX_C1;
        h = h ^ (h >> 13);
        h = h * cbf_pkg::FMIX_C2;
        h = h ^ (h >> 16);
        return h % NUM_SLOTS;
    endfunction

    // Advance the shadow store by one command; queue the present bit of a check.
    function automatic void apply_to_counters(input logic [cbf_pkg::CMD_W-1:0] cmd,
                                              input logic [cbf_pkg::KEY_W-1:0] key);
        int unsigned slot;
        bit          all_set;
        all_set = 1'b1;
        for (int unsigned idx = 0; idx < HASH_COUNT; idx++) begin
            slot = counter_slot(key, idx);
            case (cmd)
                cbf_pkg::CMD_ADD: begin
                    if (counters[slot] != cbf_pkg::CTR_MAX)
                        counters[slot] = counters[slot] + 1'b1;
                end
                cbf_pkg::CMD_REMOVE: begin
                    if (counters[slot] != cbf_pkg::CTR_ZERO)
                        counters[slot] = counters[slot] - 1'b1;
                end
                cbf_pkg::CMD_CHECK: begin
                    if (counters[slot] == cbf_pkg::CTR_ZERO) all_set = 1'b0;
                end
                default: ;
            endcase
        end
        if (cmd == cbf_pkg::CMD_CHECK) present_expected.push_back(all_set);
    endfunction

    // Find a key whose hash indices share a slot, for the directed part.
    initial begin : find_twin
        logic [cbf_pkg::KEY_W-1:0] probe;
        int unsigned               slots [HASH_COUNT];
        bit                        found;
        probe = 32'h5EED_0000;
        found = 1'b0;
        if (HASH_COUNT > 1) begin
            for (int unsigned n = 0; n < 4000000 && !found; n++) begin
                for (int unsigned i = 0; i < HASH_COUNT; i++) slots[i] = counter_slot(probe, i);
                for (int unsigned a = 0; a < HASH_COUNT; a++) begin
                    for (int unsigned b = a + 1; b < HASH_COUNT; b++) begin
                        if (slots[a] == slots[b]) found = 1'b1;
                    end
                end
                if (!found) probe = probe + 1'b1;
            end
        end
        o_twin_key = probe;
    end

    always @(posedge i_clk) begin
        bit want;
        if (i_rst_n === 1'b1) begin
            if (i_valid === 1'b1) begin
                if (present_expected.size() == 0) begin
                    $error("field present: expected no result, actual %0b", i_present);
                    fail_count++;
                end else begin
                    want = present_expected.pop_front();
                    if (i_present !== want) begin
                        $error("field present: expected %0b, actual %0b", want, i_present);
                        fail_count++;
                    end
                end
            end
            if (i_start === 1'b1 && i_busy === 1'b0) apply_to_counters(i_cmd, i_key);
        end
        pending = present_expected.size();
    end

endmodule

>>> dv/tb_counting_bloom_filter_unit.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_counting_bloom_filter_unit
// Drives add, remove and check commands into the counting Bloom filter and
// lets a checker beside it predict and compare every membership result.
// ---------------------------------------------------------------------------
module tb_counting_bloom_filter_unit;

    localparam int NUM_SLOTS  = 1048576;
    localparam int HASH_COUNT = 10;

    // Code with no operation behind it; the block must drop it.
    localparam logic [cbf_pkg::CMD_W-1:0] CMD_UNUSED = 2'd3;

    localparam int ITEM_TARGET    = 680;
    localparam int KEY_POOL_SIZE  = 12;
    // The clearing pass after reset is the longest stretch with no traffic.
    localparam int WATCHDOG_LIMIT = 4 * NUM_SLOTS + 4096;
    localparam int DRAIN_CYCLES   = 4 * HASH_COUNT + 40;

    logic                      i_clk     = 1'b0;
    logic                      i_rst_n   = 1'b0;
    logic                      start     = 1'b0;
    logic [cbf_pkg::CMD_W-1:0] i_cmd     = cbf_pkg::CMD_ADD;
    logic [cbf_pkg::KEY_W-1:0] i_key     = '0;
    logic                      busy;
    logic                      o_valid;
    logic                      o_present;

    int                        fail_count;
    int                        pending_checks;
    logic [cbf_pkg::KEY_W-1:0] twin_key;

    int                        items_sent  = 0;
    int                        idle_cycles = 0;
    bit                        no_gaps     = 1'b0;
    logic [cbf_pkg::KEY_W-1:0] key_pool [KEY_POOL_SIZE];

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    counting_bloom_filter_unit #(
        .NUM_SLOTS  (NUM_SLOTS),
        .HASH_COUNT (HASH_COUNT)
    ) dut (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .start     (start),
        .busy      (busy),
        .i_cmd     (i_cmd),
        .i_key     (i_key),
        .o_valid   (o_valid),
        .o_present (o_present)
    );

    cbf_membership_checker #(
        .NUM_SLOTS  (NUM_SLOTS),
        .HASH_COUNT (HASH_COUNT)
    ) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_cmd        (i_cmd),
        .i_key        (i_key),
        .i_valid      (o_valid),
        .i_present    (o_present),
        .o_fail_count (fail_count),
        .o_pending    (pending_checks),
        .o_twin_key   (twin_key)
    );

    // Hold one item on the command port until the block takes it. An optional
    // gap comes first, so start only ever changes once per time step.
    task automatic send_item(input logic [cbf_pkg::CMD_W-1:0] cmd,
                             input logic [cbf_pkg::KEY_W-1:0] key);
        int unsigned gap;
        if (!no_gaps && $urandom_range(99) < 6) begin
            gap = $urandom_range(1, 14);
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start <= 1'b1;
        i_cmd <= cmd;
        i_key <= key;
        @(posedge i_clk);
        while (busy !== 1'b0) @(posedge i_clk);
        if (cmd != CMD_UNUSED) items_sent++;
    endtask

    // Key with random content; now and then an all-zero or all-one word.
    function automatic logic [cbf_pkg::KEY_W-1:0] random_key();
        case ($urandom_range(19))
            0:       return '0;
            1:       return '1;
            default: return $urandom();
        endcase
    endfunction

    // Well-formed life of one key: a run of adds, checks along the way,
    // then a run of removes that may drain the counters or leave them set.
    task automatic key_episode(input logic [cbf_pkg::KEY_W-1:0] key);
        int unsigned adds;
        int unsigned removes;
        adds    = $urandom_range(1, 18);
        removes = $urandom_range(0, adds + 3);
        for (int unsigned n = 0; n < adds; n++) begin
            send_item(cbf_pkg::CMD_ADD, key);
            if ($urandom_range(3) == 0) send_item(cbf_pkg::CMD_CHECK, key);
        end
        send_item(cbf_pkg::CMD_CHECK, key);
        if ($urandom_range(1) == 0)
            send_item(cbf_pkg::CMD_CHECK, key_pool[$urandom_range(KEY_POOL_SIZE - 1)]);
        for (int unsigned n = 0; n < removes; n++) begin
            send_item(cbf_pkg::CMD_REMOVE, key);
            if ($urandom_range(3) == 0) send_item(cbf_pkg::CMD_CHECK, key);
        end
        send_item(cbf_pkg::CMD_CHECK, key);
    endtask

    // Noise: any code, pool or fresh key, in a short burst.
    task automatic noise_burst();
        int unsigned               len;
        int unsigned               code;
        logic [cbf_pkg::CMD_W-1:0] cmd;
        len = $urandom_range(1, 6);
        for (int unsigned n = 0; n < len; n++) begin
            code = $urandom_range(3);
            cmd  = code[cbf_pkg::CMD_W-1:0];
            send_item(cmd,
                      $urandom_range(1) ? key_pool[$urandom_range(KEY_POOL_SIZE - 1)]
                                        : random_key());
        end
    endtask

    initial begin : stimulus
        foreach (key_pool[k]) key_pool[k] = random_key();

        // Hold reset, then release it on a clock edge.
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty store, removal at zero, extreme keys, dropped code,
        // a key that hits one slot twice, and near-miss keys.
        send_item(cbf_pkg::CMD_CHECK,  32'h0000_0000);
        send_item(cbf_pkg::CMD_REMOVE, 32'h0000_0000);
        send_item(cbf_pkg::CMD_CHECK,  32'h0000_0000);
        send_item(cbf_pkg::CMD_ADD,    32'h0000_0000);
        send_item(cbf_pkg::CMD_CHECK,  32'h0000_0000);
        send_item(cbf_pkg::CMD_ADD,    32'hFFFF_FFFF);
        send_item(cbf_pkg::CMD_CHECK,  32'hFFFF_FFFF);
        send_item(cbf_pkg::CMD_REMOVE, 32'h0000_0000);
        send_item(cbf_pkg::CMD_CHECK,  32'h0000_0000);
        send_item(cbf_pkg::CMD_CHECK,  32'hFFFF_FFFF);
        send_item(CMD_UNUSED,          32'hA5A5_A5A5);
        send_item(CMD_UNUSED,          32'hFFFF_FFFF);
        send_item(cbf_pkg::CMD_CHECK,  32'h5A5A_5A5A);
        send_item(cbf_pkg::CMD_ADD,    twin_key);
        send_item(cbf_pkg::CMD_CHECK,  twin_key);
        send_item(cbf_pkg::CMD_REMOVE, twin_key);
        send_item(cbf_pkg::CMD_CHECK,  twin_key);
        send_item(cbf_pkg::CMD_REMOVE, 32'hFFFF_FFFF);
        send_item(cbf_pkg::CMD_CHECK,  32'hFFFF_FFFF);
        send_item(cbf_pkg::CMD_ADD,    32'h8000_0001);
        send_item(cbf_pkg::CMD_CHECK,  32'h8000_0001);
        send_item(cbf_pkg::CMD_CHECK,  32'h0000_0001);
        send_item(cbf_pkg::CMD_REMOVE, 32'h8000_0001);

        // Random: mostly key lifetimes over a small pool so counters collide
        // and saturate, with noise bursts mixed in.
        while (items_sent < ITEM_TARGET) begin
            no_gaps = (items_sent >= 250 && items_sent < 400);
            if ($urandom_range(99) < 75) begin
                key_episode($urandom_range(3) == 0 ? random_key()
                                                    : key_pool[$urandom_range(KEY_POOL_SIZE - 1)]);
            end else begin
                noise_burst();
            end
        end
        start <= 1'b0;

        // Let the last accepted check reach the checker, then drain.
        @(posedge i_clk);
        while (pending_checks != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && pending_checks == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Stop a hung run: count cycles in which neither channel moves an item.
    always @(posedge i_clk) begin
        if ((start === 1'b1 && busy === 1'b0) || o_valid === 1'b1) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

endmodule

>>> filelist.f
+incdir+design
design/cbf_pkg.sv
design/cbf_ram.sv
design/cbf_front.sv
design/cbf_fifo.sv
design/cbf_back.sv
design/counting_bloom_filter_unit.sv
design/cbf_checker.sv
dv/cbf_membership_checker.sv
dv/tb_counting_bloom_filter_unit.sv
